FILE: rtl/gcol_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the grid cell owner locator.
// Used by gcol_lane and grid_cell_owner_locator; depends on nothing.
package gcol_pkg;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_LOCATE = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam int unsigned PADDR_BITS = 3;
	localparam logic [PADDR_BITS-1:0] ADDR_DIMS = 3'd0;
	localparam logic [1:0] DIMS_RESET = 2'd2;
	localparam logic [1:0] DIMS_3D = 2'd3;

	localparam int unsigned CELL_BITS = 10;

	typedef struct packed {
		logic start;
		logic first;
	} lane_ctl_t;

	typedef struct packed {
		logic busy;
		logic oor;
	} lane_sts_t;

endpackage

FILE: rtl/grid_cell_owner_locator.sv
`timescale 1ns / 1ps
// Top level of the grid cell owner locator: item and result channels, APB register, three lanes.
// Depends on gcol_pkg and gcol_lane.

// Three axis lanes, each with its own node table and one read port, walk their indices side by
// side; a locate beat lasts until the slowest lane walk is done, with one table read and compare
// per node step, and a load beat writes at most one table entry. The result
// sits in an output register, so the next beat is taken while a result still waits. The node
// tables have no reset: every entry a walk can touch must be loaded first. Register dims at
// byte address 0 selects 3D with the value 3; other values leave the z axis untouched.
module grid_cell_owner_locator #(
	parameter int GRID_NODES = 1024,
	parameter int COORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gcol_pkg::PADDR_BITS-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                func,
	input  logic [1:0]                          axis,
	input  logic [9:0]                          node_index,
	input  logic signed [31:0]                  node_coord,
	input  logic signed [31:0]                  point_x,
	input  logic signed [31:0]                  point_y,
	input  logic signed [31:0]                  point_z,
	input  logic                                first_point,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [9:0]                          cell_i,
	output logic [9:0]                          cell_j,
	output logic [9:0]                          cell_k,
	output logic                                out_of_range
);

	localparam int AW = $clog2(GRID_NODES);

	typedef enum logic {
		T_IDLE,
		T_WALK
	} state_t;

	state_t state_q;
	logic [1:0] dims_q;
	logic use_z_q;
	logic result_valid_q;
	logic [9:0] cell_i_q;
	logic [9:0] cell_j_q;
	logic [9:0] cell_k_q;
	logic oor_q;

	logic signed [COORD_BITS-1:0] node_c;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic signed [COORD_BITS-1:0] pz;

	logic accept;
	logic is_load;
	logic is_locate;
	logic in_table;
	logic use_z_now;
	logic collect;
	logic [AW-1:0] wr_addr;

	gcol_pkg::lane_ctl_t ctl_xy;
	gcol_pkg::lane_ctl_t ctl_z;
	gcol_pkg::lane_sts_t sts_x;
	gcol_pkg::lane_sts_t sts_y;
	gcol_pkg::lane_sts_t sts_z;
	logic [AW-1:0] idx_x;
	logic [AW-1:0] idx_y;
	logic [AW-1:0] idx_z;

	generate
		if (COORD_BITS >= 32) begin : g_coord_ext
			assign node_c = COORD_BITS'(node_coord);
			assign px = COORD_BITS'(point_x);
			assign py = COORD_BITS'(point_y);
			assign pz = COORD_BITS'(point_z);
		end else begin : g_coord_wrap
			assign node_c = node_coord[COORD_BITS-1:0];
			assign px = point_x[COORD_BITS-1:0];
			assign py = point_y[COORD_BITS-1:0];
			assign pz = point_z[COORD_BITS-1:0];
		end
	endgenerate

	assign pready = 1'b1;
	assign prdata = (paddr == gcol_pkg::ADDR_DIMS) ? {30'd0, dims_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= gcol_pkg::DIMS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == gcol_pkg::ADDR_DIMS)) begin
			dims_q <= pwdata[1:0];
		end
	end

	assign item_ready = (state_q == T_IDLE);
	assign accept = item_valid && item_ready;
	assign is_load = accept && (func == gcol_pkg::FUNC_LOAD);
	assign is_locate = accept && (func == gcol_pkg::FUNC_LOCATE);
	assign in_table = (32'(node_index) < GRID_NODES);
	assign wr_addr = AW'(node_index);
	assign use_z_now = (dims_q == gcol_pkg::DIMS_3D);

	assign ctl_xy.start = is_locate;
	assign ctl_xy.first = first_point;
	assign ctl_z.start = is_locate && use_z_now;
	assign ctl_z.first = first_point;

	gcol_lane #(.NODES(GRID_NODES), .CW(COORD_BITS)) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_xy),
		.p       (px),
		.wr_en   (is_load && in_table && (axis == gcol_pkg::AXIS_X)),
		.wr_addr (wr_addr),
		.wr_data (node_c),
		.sts     (sts_x),
		.idx     (idx_x)
	);

	gcol_lane #(.NODES(GRID_NODES), .CW(COORD_BITS)) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_xy),
		.p       (py),
		.wr_en   (is_load && in_table && (axis == gcol_pkg::AXIS_Y)),
		.wr_addr (wr_addr),
		.wr_data (node_c),
		.sts     (sts_y),
		.idx     (idx_y)
	);

	gcol_lane #(.NODES(GRID_NODES), .CW(COORD_BITS)) u_lane_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_z),
		.p       (pz),
		.wr_en   (is_load && in_table && (axis == gcol_pkg::AXIS_Z)),
		.wr_addr (wr_addr),
		.wr_data (node_c),
		.sts     (sts_z),
		.idx     (idx_z)
	);

	assign collect = (state_q == T_WALK) && !sts_x.busy && !sts_y.busy && !sts_z.busy
		&& (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			use_z_q <= 1'b0;
			result_valid_q <= 1'b0;
			cell_i_q <= '0;
			cell_j_q <= '0;
			cell_k_q <= '0;
			oor_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && !collect) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (is_locate) begin
						use_z_q <= use_z_now;
						state_q <= T_WALK;
					end
				end
				T_WALK: begin
					if (collect) begin
						cell_i_q <= 10'(idx_x);
						cell_j_q <= 10'(idx_y);
						cell_k_q <= use_z_q ? 10'(idx_z) : 10'd0;
						oor_q <= sts_x.oor || sts_y.oor || (use_z_q && sts_z.oor);
						result_valid_q <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign cell_i = cell_i_q;
	assign cell_j = cell_j_q;
	assign cell_k = cell_k_q;
	assign out_of_range = oor_q;

`ifndef NO_ASSERTIONS
	a_lanes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_IDLE) |-> !(sts_x.busy || sts_y.busy || sts_z.busy))
		else $error("lane busy while the block is idle");

	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == T_WALK))
		else $error("result raised without a walk");

	a_2d_no_k: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) && !$past(use_z_q) |-> (cell_k == 10'd0))
		else $error("nonzero cell_k in 2D");

	a_cell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (GRID_NODES <= 1024) |-> (32'(cell_i) <= GRID_NODES - 2))
		else $error("cell_i beyond last cell");
`endif

endmodule

FILE: rtl/gcol_lane.sv
`timescale 1ns / 1ps
// One axis lane: the node coordinate table of the axis and the walk that keeps its cell index.
// Depends on gcol_pkg for the lane control and status structs.
module gcol_lane #(
	parameter int NODES = 1024,
	parameter int CW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gcol_pkg::lane_ctl_t           ctl,
	input  logic signed [CW-1:0]          p,
	input  logic                          wr_en,
	input  logic [$clog2(NODES)-1:0]      wr_addr,
	input  logic signed [CW-1:0]          wr_data,
	output gcol_pkg::lane_sts_t           sts,
	output logic [$clog2(NODES)-1:0]      idx
);

	localparam int AW = $clog2(NODES);
	localparam logic [AW-1:0] LAST = AW'(NODES - 2);

	typedef enum logic {
		L_IDLE,
		L_WALK
	} state_t;

	state_t state_q;
	logic [AW-1:0] idx_q;
	logic signed [CW-1:0] last_q;
	logic signed [CW-1:0] p_q;
	logic down_q;
	logic oor_q;

	logic signed [CW-1:0] mem [NODES];
	logic signed [CW-1:0] rd_data_q;

	logic [AW-1:0] start_i;
	logic start_down;
	logic hit;
	logic at_end;
	logic step;
	logic [AW-1:0] next_idx;
	logic [AW-1:0] rd_addr;
	logic rd_en;

	assign start_i = ctl.first ? '0 : idx_q;
	assign start_down = !ctl.first && (p < last_q);
	assign hit = down_q ? (rd_data_q > p_q) : (rd_data_q < p_q);
	assign at_end = down_q ? (idx_q == '0) : (idx_q == LAST);
	assign step = (state_q == L_WALK) && hit && !at_end;
	assign next_idx = down_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));

	always_comb begin
		if (state_q == L_IDLE) begin
			rd_addr = start_down ? start_i : (start_i + AW'(1));
		end else begin
			rd_addr = down_q ? next_idx : (next_idx + AW'(1));
		end
	end

	assign rd_en = ((state_q == L_IDLE) && ctl.start) || step;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			idx_q <= '0;
			last_q <= '0;
			p_q <= '0;
			down_q <= 1'b0;
			oor_q <= 1'b0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						idx_q <= start_i;
						down_q <= start_down;
						p_q <= p;
						last_q <= p;
						oor_q <= 1'b0;
						state_q <= L_WALK;
					end
				end
				L_WALK: begin
					if (!hit) begin
						state_q <= L_IDLE;
					end else if (at_end) begin
						oor_q <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						idx_q <= next_idx;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign sts.busy = (state_q == L_WALK);
	assign sts.oor = oor_q;
	assign idx = idx_q;

`ifndef NO_ASSERTIONS
	a_idx_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST)
		else $error("lane index beyond last cell");

	a_step_stays_in_dir: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (state_q == L_WALK) && (down_q == $past(down_q)))
		else $error("walk changed direction or stopped after a step");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> (state_q == L_IDLE))
		else $error("lane started while walking");
`endif

endmodule

FILE: bench/grid_cell_owner_locator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of grid_cell_owner_locator: loads node tables, sends locate beats
// and checks every owning cell against an in-bench walk of the same tables.
// Depends on gcol_pkg and the grid_cell_owner_locator RTL.
module grid_cell_owner_locator_tb;

	localparam logic [1:0] AXIS_NONE = 2'd3;
	localparam int unsigned LAST_CELL = 1022;
	localparam int LAY_WIDE = 0;
	localparam int LAY_NARROW = 1;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic        func;
		logic [1:0]  axis;
		logic [9:0]  node_index;
		logic [31:0] node_coord;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        first;
	} grid_beat_t;

	typedef struct packed {
		logic [9:0] ci;
		logic [9:0] cj;
		logic [9:0] ck;
		logic       oor;
	} cell_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [gcol_pkg::PADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [9:0] cell_i, cell_j, cell_k;
	logic out_of_range;

	grid_beat_t beat_drv = '0;
	grid_beat_t grid_beats[$];
	cell_hit_t owner_cells[$];
	logic item_fire = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_count = 0;
	int mismatches = 0;

	logic signed [31:0] grid_tab [0:2][0:1023];
	int unsigned cell_at [0:2];
	logic signed [31:0] last_pt [0:2];
	logic [1:0] cfg_dims = gcol_pkg::DIMS_RESET;
	longint gen_pt [0:2];

	grid_cell_owner_locator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.func(beat_drv.func),
		.axis(beat_drv.axis),
		.node_index(beat_drv.node_index),
		.node_coord(beat_drv.node_coord),
		.point_x(beat_drv.px),
		.point_y(beat_drv.py),
		.point_z(beat_drv.pz),
		.first_point(beat_drv.first),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cell_i(cell_i),
		.cell_j(cell_j),
		.cell_k(cell_k),
		.out_of_range(out_of_range)
	);

	always #5 clk = ~clk;

	function automatic bit walk_cell(int a, logic signed [31:0] p, bit first);
		int unsigned i;
		bit clamped;
		i = first ? 0 : cell_at[a];
		clamped = 1'b0;
		if (i > LAST_CELL)
			i = LAST_CELL;
		if (!first && p < last_pt[a]) begin
			while (grid_tab[a][i] > p) begin
				if (i == 0) begin
					clamped = 1'b1;
					break;
				end
				i--;
			end
		end else begin
			while (grid_tab[a][i + 1] < p) begin
				if (i >= LAST_CELL) begin
					clamped = 1'b1;
					break;
				end
				i++;
			end
		end
		cell_at[a] = i;
		last_pt[a] = p;
		return clamped;
	endfunction

	function automatic void predict_owner(grid_beat_t b);
		cell_hit_t hit;
		bit oor;
		if (b.func == gcol_pkg::FUNC_LOAD) begin
			if (b.axis != AXIS_NONE)
				grid_tab[b.axis][b.node_index] = $signed(b.node_coord);
		end else begin
			oor = walk_cell(0, $signed(b.px), b.first);
			oor |= walk_cell(1, $signed(b.py), b.first);
			if (cfg_dims == gcol_pkg::DIMS_3D)
				oor |= walk_cell(2, $signed(b.pz), b.first);
			hit.ci = 10'(cell_at[0]);
			hit.cj = 10'(cell_at[1]);
			hit.ck = (cfg_dims == gcol_pkg::DIMS_3D) ? 10'(cell_at[2]) : 10'd0;
			hit.oor = oor;
			owner_cells.insert(owner_cells.size(), hit);
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_owner();
		cell_hit_t want;
		if (owner_cells.size() == 0) begin
			$display("%0t: result beat with nothing expected, got cell (%0d,%0d,%0d) oor %0b",
				$time, cell_i, cell_j, cell_k, out_of_range);
			mismatches++;
		end else begin
			want = owner_cells.pop_front();
			check_field("cell_i", 32'(want.ci), 32'(cell_i));
			check_field("cell_j", 32'(want.cj), 32'(cell_j));
			check_field("cell_k", 32'(want.ck), 32'(cell_k));
			check_field("out_of_range", 32'(want.oor), 32'(out_of_range));
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			item_fire <= 1'b0;
		end else begin
			if (result_valid && result_ready)
				check_owner();
			if (item_valid && item_ready)
				predict_owner(beat_drv);
			item_fire <= item_valid && item_ready;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (item_fire)
				grid_beats.delete(0);
			if (!item_valid || item_fire) begin
				if (grid_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_drv <= grid_beats[0];
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req && hold_count < HOLD_CYCLES) begin
			hold_count++;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint layout_coord(int lay, int a, int n);
		if (lay == LAY_WIDE)
			return -64'sd2147483648 + longint'(n) * 4194304;
		return longint'(n - 512) * 65536 + longint'(a) * 4096;
	endfunction

	function automatic int unsigned layout_step(int lay);
		return (lay == LAY_WIDE) ? 4194304 : 65536;
	endfunction

	task automatic push_load(logic [1:0] a, int n, logic [31:0] coord);
		grid_beat_t b;
		b = '0;
		b.func = gcol_pkg::FUNC_LOAD;
		b.axis = a;
		b.node_index = n[9:0];
		b.node_coord = coord;
		b.px = $urandom;
		b.py = $urandom;
		b.pz = $urandom;
		b.first = 1'($urandom_range(1));
		grid_beats.insert(grid_beats.size(), b);
	endtask

	task automatic push_locate(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit first);
		grid_beat_t b;
		b.func = gcol_pkg::FUNC_LOCATE;
		b.axis = 2'($urandom_range(3));
		b.node_index = 10'($urandom_range(1023));
		b.node_coord = $urandom;
		b.px = x;
		b.py = y;
		b.pz = z;
		b.first = first;
		grid_beats.insert(grid_beats.size(), b);
		gen_pt[0] = longint'($signed(x));
		gen_pt[1] = longint'($signed(y));
		gen_pt[2] = longint'($signed(z));
	endtask

	task automatic load_layout(int lay);
		for (int a = 0; a < 3; a++)
			for (int n = 0; n < 1024; n++)
				push_load(a[1:0], n, sat32(layout_coord(lay, a, n)));
	endtask

	task automatic random_beats(int lay, int count);
		int unsigned stp;
		int r, m, n;
		logic [1:0] a;
		logic [31:0] coord;
		longint p [0:2];
		stp = layout_step(lay);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				a = 2'($urandom_range(3));
				n = $urandom_range(1023);
				if ($urandom_range(6) == 0)
					coord = $urandom;
				else
					coord = sat32(layout_coord(lay, a, n) + $urandom_range(stp / 4));
				push_load(a, n, coord);
			end else begin
				m = $urandom_range(99);
				for (int ax = 0; ax < 3; ax++) begin
					if (m < 5)
						p[ax] = layout_coord(lay, ax, $urandom_range(40))
							+ $urandom_range(stp - 1);
					else if (m < 7)
						p[ax] = longint'($signed($urandom));
					else if (m < 10 && $urandom_range(1) == 1)
						p[ax] = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
					else
						p[ax] = gen_pt[ax] + longint'($urandom_range(6 * stp))
							- 3 * longint'(stp);
				end
				push_locate(sat32(p[0]), sat32(p[1]), sat32(p[2]), m < 7);
			end
		end
	endtask

	task automatic settle();
		wait (grid_beats.size() == 0 && !item_valid && owner_cells.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= gcol_pkg::ADDR_DIMS;
		pwdata <= {30'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg_dims = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[1:0] !== val) begin
			$display("%0t: dims readback expected %0d, got %0d", $time, val, prdata[1:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(logic [1:0] dims_val, int idle_pct, int stall_pct, int lay,
		bit reload, int count);
		settle();
		write_dims(dims_val);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (reload)
			load_layout(lay);
		random_beats(lay, count);
	endtask

	initial begin
		for (int a = 0; a < 3; a++) begin
			cell_at[a] = 0;
			last_pt[a] = '0;
			gen_pt[a] = 0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		write_dims(gcol_pkg::DIMS_RESET);
		load_layout(LAY_WIDE);
		// Ignored loads, then the top node pushed to the largest coordinate.
		push_load(AXIS_NONE, 0, 32'h80000000);
		push_load(AXIS_NONE, 1023, 32'h7fffffff);
		push_load(gcol_pkg::AXIS_X, 1023, 32'h7fffffff);
		// The first point after reset is not marked first, and equals the kept point.
		push_locate(32'h0, 32'h0, 32'h0, 1'b0);
		push_locate(32'hff400007, 32'h0, 32'h12345678, 1'b0);
		push_locate(32'hff400007, 32'h0, 32'h12345678, 1'b0);
		push_locate(32'h81400000, 32'h81400000, 32'h81400000, 1'b1);
		push_locate(32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
		push_locate(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
		// Raise the bottom node so that a walk down runs off the table.
		push_load(gcol_pkg::AXIS_X, 0, 32'h80000001);
		push_locate(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
		push_locate(32'h0, 32'h0, 32'h0, 1'b0);

		run_phase(gcol_pkg::DIMS_3D, 49, 0, LAY_WIDE, 1'b0, 400);
		settle();
		hold_req = 1'b1;
		run_phase(2'd0, 0, 49, LAY_WIDE, 1'b0, 400);
		run_phase(gcol_pkg::DIMS_3D, 32, 32, LAY_NARROW, 1'b1, 400);
		run_phase(2'd1, 0, 0, LAY_NARROW, 1'b0, 400);

		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
